### design/swar_pkg.sv
// ----------------------------------------------------------------------------
// swar_pkg
// Shared widths, codes and types of the stop-and-wait ACK receiver.
// ----------------------------------------------------------------------------
package swar_pkg;

	localparam int PAYLOAD_BYTES = 10;   // byte lanes in use, 1 to 10
	localparam int RAW_BYTES     = 10;   // bytes carried by the payload ports
	localparam int BYTE_W        = 8;
	localparam int COUNT_W       = 4;
	localparam int LEN_W         = 4;
	localparam int SUM_W         = 32;
	localparam int LOW_W         = 64;
	localparam int HIGH_W        = 16;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_DUP    = 2'd1,
		VERDICT_REJECT = 2'd2,
		VERDICT_END    = 2'd3
	} verdict_t;

	typedef logic [BYTE_W-1:0] byte_t;

	// packet after the byte lanes, the merge stage works from this
	typedef struct packed {
		logic                     seq_bit;
		logic [LEN_W-1:0]         pkt_length;
		logic [SUM_W-1:0]         rx_checksum;
		byte_t [RAW_BYTES-1:0]    kept;
		logic [COUNT_W-1:0]       count;
	} lane_pkt_t;

	typedef struct packed {
		logic                     ack_seq;
		logic                     ack_sum;
		verdict_t                 verdict;
		logic                     deliver;
		logic                     is_name;
		logic [LOW_W-1:0]         out_low;
		logic [HIGH_W-1:0]        out_high;
		logic [COUNT_W-1:0]       out_count;
	} ack_result_t;

endpackage

### design/stop_wait_ack_receiver_unit.sv
// ----------------------------------------------------------------------------
// stop_wait_ack_receiver_unit
// Stop-and-wait receiver: checks each packet, emits one ACK with a verdict
// and passes accepted payload on.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | seq_bit pkt_length rx_checksum payload_low
//          |                      | payload_high payload_count
//  out     | out_valid / out_ready| ack_seq ack_sum verdict deliver is_name
//          |                      | out_low out_high out_count
//
// one packet per cycle while the output does not stall; from input transfer to out_valid
// a packet passes the byte lane register, then merge and result register
// receiver state is updated as a result enters the output register, so
// packets following back to back see the state of the one before
// reset clears the receiver state and both valid stages
// a stalled output holds its result and the lane stage holds one more packet
// ----------------------------------------------------------------------------
module stop_wait_ack_receiver_unit
	import swar_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                seq_bit,
	input  logic [LEN_W-1:0]    pkt_length,
	input  logic signed [SUM_W-1:0] rx_checksum,
	input  logic [LOW_W-1:0]    payload_low,
	input  logic [HIGH_W-1:0]   payload_high,
	input  logic [COUNT_W-1:0]  payload_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                ack_seq,
	output logic                ack_sum,
	output logic [1:0]          verdict,
	output logic                deliver,
	output logic                is_name,
	output logic [LOW_W-1:0]    out_low,
	output logic [HIGH_W-1:0]   out_high,
	output logic [COUNT_W-1:0]  out_count
);

	logic [RAW_BYTES*BYTE_W-1:0] raw_all;
	byte_t [RAW_BYTES-1:0]       kept;
	logic [COUNT_W-1:0]          count_clamped;
	lane_pkt_t                   pkt_d;
	lane_pkt_t                   pkt_s1;
	logic                        pkt_valid_s1;
	logic                        take;
	ack_result_t                 result;

	assign raw_all = {payload_high, payload_low};
	assign count_clamped = (payload_count > COUNT_W'(PAYLOAD_BYTES))
		? COUNT_W'(PAYLOAD_BYTES) : payload_count;

	for (genvar i = 0; i < RAW_BYTES; i++) begin : g_lane
		if (i < PAYLOAD_BYTES) begin : g_used
			swar_lane u_lane (
				.lane_idx  (COUNT_W'(i)),
				.count     (count_clamped),
				.data_byte (raw_all[i*BYTE_W +: BYTE_W]),
				.kept_byte (kept[i])
			);
		end else begin : g_unused
			assign kept[i] = '0;
		end
	end

	always_comb begin
		pkt_d.seq_bit     = seq_bit;
		pkt_d.pkt_length  = pkt_length;
		pkt_d.rx_checksum = rx_checksum;
		pkt_d.kept        = kept;
		pkt_d.count       = count_clamped;
	end

	assign in_ready = !pkt_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			pkt_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pkt_s1 <= pkt_d;
		end
	end

	swar_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid_s1),
		.pkt       (pkt_s1),
		.take      (take),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign ack_seq   = result.ack_seq;
	assign ack_sum   = result.ack_sum;
	assign verdict   = result.verdict;
	assign deliver   = result.deliver;
	assign is_name   = result.is_name;
	assign out_low   = result.out_low;
	assign out_high  = result.out_high;
	assign out_count = result.out_count;

endmodule

### design/swar_lane.sv
// ----------------------------------------------------------------------------
// swar_lane
// One payload byte lane: keeps the byte when it lies below the byte count.
// ----------------------------------------------------------------------------
module swar_lane
	import swar_pkg::*;
(
	input  logic [COUNT_W-1:0] lane_idx,
	input  logic [COUNT_W-1:0] count,
	input  byte_t              data_byte,
	output byte_t              kept_byte
);

	assign kept_byte = (lane_idx < count) ? data_byte : '0;

endmodule

### design/swar_merge.sv
// ----------------------------------------------------------------------------
// swar_merge
// Merges the lane bytes into the checksum, decides the verdict against the
// receiver state and holds the result until the transfer out completes.
// ----------------------------------------------------------------------------
module swar_merge
	import swar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	input  lane_pkt_t   pkt,
	output logic        take,
	input  logic        out_ready,
	output logic        out_valid,
	output ack_result_t result
);

	logic              expected_seq_q;
	logic [SUM_W-1:0]  last_sum_q;
	logic              stored_ack_q;
	logic              name_seen_q;
	logic              out_valid_q;
	ack_result_t       result_q;

	byte_t             sum;
	logic              prev_seq;
	logic              is_end;
	logic              is_accept;
	logic              is_dup;
	logic [RAW_BYTES*BYTE_W-1:0] data_all;
	ack_result_t       res_d;

	assign take = pkt_valid && (!out_valid_q || out_ready);

	always_comb begin
		sum = byte_t'(pkt.seq_bit) ^ byte_t'(pkt.pkt_length);
		for (int i = 0; i < RAW_BYTES; i++) begin
			sum = sum ^ pkt.kept[i];
		end
		data_all = pkt.kept;
	end

	assign prev_seq  = ~expected_seq_q;
	assign is_end    = (pkt.pkt_length == '0);
	assign is_accept = !is_end && (pkt.seq_bit == expected_seq_q)
		&& ({{(SUM_W-BYTE_W){1'b0}}, sum} == pkt.rx_checksum);
	assign is_dup    = !is_end && !is_accept && (pkt.rx_checksum == last_sum_q);

	always_comb begin
		res_d = '0;
		if (is_end) begin
			res_d.ack_seq = expected_seq_q;
			res_d.ack_sum = expected_seq_q;
			res_d.verdict = VERDICT_END;
		end else if (is_accept) begin
			res_d.ack_seq   = expected_seq_q;
			res_d.ack_sum   = expected_seq_q;
			res_d.verdict   = VERDICT_ACCEPT;
			res_d.deliver   = 1'b1;
			res_d.is_name   = !name_seen_q;
			res_d.out_low   = data_all[LOW_W-1:0];
			res_d.out_high  = data_all[LOW_W +: HIGH_W];
			res_d.out_count = pkt.count;
		end else if (is_dup) begin
			res_d.ack_seq = prev_seq;
			res_d.ack_sum = prev_seq;
			res_d.verdict = VERDICT_DUP;
		end else begin
			res_d.ack_seq = prev_seq;
			res_d.ack_sum = stored_ack_q;
			res_d.verdict = VERDICT_REJECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q <= 1'b0;
			last_sum_q     <= '1;
			stored_ack_q   <= 1'b0;
			name_seen_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				if (is_end) begin
					expected_seq_q <= 1'b0;
					last_sum_q     <= '1;
					stored_ack_q   <= 1'b0;
					name_seen_q    <= 1'b0;
				end else if (is_accept) begin
					expected_seq_q <= ~expected_seq_q;
					last_sum_q     <= pkt.rx_checksum;
					stored_ack_q   <= expected_seq_q;
					name_seen_q    <= 1'b1;
				end else if (is_dup) begin
					stored_ack_q   <= prev_seq;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule
